[sv/single_switch_menu_selector_macros.svh]
// Assertion macros for the single switch menu selector.
`ifndef SINGLE_SWITCH_MENU_SELECTOR_MACROS_SVH
`define SINGLE_SWITCH_MENU_SELECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define SSMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssms assertion failed");

// Next-cycle implication, disabled during reset.
`define SSMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssms assertion failed");

`else

`define SSMS_ASSERT_NOW(label, clk, rst, ante, cons)

`define SSMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/ssms_pkg.sv]
// Shared types and constants for the single switch menu selector.
`timescale 1ns / 1ps

package ssms_pkg;

  localparam logic [2:0] ITEM_NONE  = 3'd0;
  localparam logic [2:0] ITEM_FIRST = 3'd1;
  localparam logic [2:0] ITEM_SAFEHOME  = 3'd2;
  localparam logic [2:0] ITEM_TRACKBACK = 3'd3;
  localparam logic [2:0] ITEM_TURTLE    = 3'd4;
  localparam logic [2:0] ITEM_LAST  = 3'd6;
  localparam logic [2:0] ITEM_END   = 3'd7;

  localparam int          CFG_INDEX_WIDTH = 2;
  localparam logic [1:0]  REG_HOLD_MS     = 2'd0;
  localparam logic [1:0]  REG_CYCLE_MS    = 2'd1;
  localparam logic [15:0] HOLD_MS_RESET   = 16'd3000;
  localparam logic [15:0] CYCLE_MS_RESET  = 16'd1500;

  typedef enum logic [1:0] {
    PHASE_FIRST    = 2'd0,
    PHASE_RELEASED = 2'd1,
    PHASE_PRESSED  = 2'd2
  } phase_t;

  // Menu control state apart from the time stamp.
  typedef struct packed {
    phase_t     press_phase;
    logic [2:0] current_item;
    logic [2:0] toggle_flags;  // bit0 safehome, bit1 trackback, bit2 turtle
  } menu_state_t;

  typedef struct packed {
    logic [2:0] selection;
    logic [2:0] fired_function;
    logic       safehome_suspended;
    logic       trackback_suspended;
    logic       turtle_on;
    logic       none_available;
  } result_t;

endpackage

[sv/ssms_step.sv]
// Combinational next-state and result logic for one menu tick.
`timescale 1ns / 1ps

module ssms_step #(
  parameter int TIME_WIDTH = 32
) (
  input  logic [TIME_WIDTH-1:0]  now,
  input  logic                   switch_on,
  input  logic [5:0]             available_mask,
  input  logic [15:0]            hold_ms,
  input  logic [15:0]            cycle_ms,
  input  logic [TIME_WIDTH-1:0]  phase_time,
  input  ssms_pkg::menu_state_t  state,
  output logic [TIME_WIDTH-1:0]  phase_time_next,
  output ssms_pkg::menu_state_t  state_next,
  output ssms_pkg::result_t      result
);

  import ssms_pkg::*;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  idle;
  logic                  hold_done;
  logic                  cycle_done;
  menu_state_t           state_mid;
  logic [2:0]            item_mid;
  logic [2:0]            found;
  logic [2:0]            fired;
  logic                  none;

  assign elapsed    = now - phase_time;
  assign idle       = (phase_time == '0);
  assign hold_done  = (elapsed > TIME_WIDTH'(hold_ms));
  // In the first-release phase the timer restarts at now, so nothing has elapsed.
  assign cycle_done = (state.press_phase != PHASE_FIRST) && (elapsed > TIME_WIDTH'(cycle_ms));

  // Switch handling: open, hold to apply, release to step or cancel.
  always_comb begin
    phase_time_next         = phase_time;
    state_mid               = state;
    fired                   = ITEM_NONE;
    if (switch_on) begin
      if (idle) begin
        phase_time_next        = now;
        state_mid.current_item = ITEM_FIRST;
      end else if (state.press_phase != PHASE_FIRST && state.current_item != ITEM_END) begin
        state_mid.press_phase = PHASE_PRESSED;
        if (hold_done) begin
          if (state.current_item != ITEM_NONE) begin
            fired = state.current_item;
          end
          case (state.current_item)
            ITEM_SAFEHOME:  state_mid.toggle_flags[0] = ~state.toggle_flags[0];
            ITEM_TRACKBACK: state_mid.toggle_flags[1] = ~state.toggle_flags[1];
            ITEM_TURTLE:    state_mid.toggle_flags[2] = ~state.toggle_flags[2];
            default: ;
          endcase
          state_mid.current_item = ITEM_END;
        end
      end
    end else if (!idle) begin
      if (state.press_phase != PHASE_FIRST &&
          (state.press_phase == PHASE_PRESSED || state.current_item == ITEM_NONE)) begin
        phase_time_next        = '0;
        state_mid.press_phase  = PHASE_FIRST;
        state_mid.current_item = ITEM_NONE;
      end else begin
        if (state.press_phase == PHASE_FIRST) begin
          phase_time_next = now;
        end
        if (cycle_done) begin
          state_mid.current_item = (state.current_item >= ITEM_LAST) ?
                                   ITEM_FIRST : state.current_item + 3'd1;
          phase_time_next        = now;
        end
        state_mid.press_phase = PHASE_RELEASED;
      end
    end
  end

  assign item_mid = state_mid.current_item;

  // Lowest available function at or above the selection.
  always_comb begin
    found = ITEM_NONE;
    for (int k = 6; k >= 1; k--) begin
      if (item_mid <= 3'(k) && available_mask[k-1]) begin
        found = 3'(k);
      end
    end
  end

  logic [2:0] selection;

  always_comb begin
    selection = item_mid;
    none      = 1'b0;
    if (item_mid != ITEM_NONE && item_mid != ITEM_END) begin
      if (found != ITEM_NONE) begin
        selection = found;
      end else if (item_mid == ITEM_FIRST) begin
        selection = ITEM_NONE;
        none      = 1'b1;
      end else begin
        selection = ITEM_FIRST;
      end
    end
  end

  // Final state carries the scanned selection.
  always_comb begin
    state_next              = state_mid;
    state_next.current_item = selection;
  end

  assign result.selection           = selection;
  assign result.fired_function      = fired;
  assign result.safehome_suspended  = state_mid.toggle_flags[0];
  assign result.trackback_suspended = state_mid.toggle_flags[1];
  assign result.turtle_on           = state_mid.toggle_flags[2];
  assign result.none_available      = none;

endmodule

[sv/single_switch_menu_selector.sv]
// Top level of the single switch menu selector: input stage, tick logic, result register.
// Path: the input stage holds an accepted item for the combinational tick logic, which
// loads the result register. Throughput: one item per cycle while results are taken;
// the input stage takes a new item while a result waits only when the stage is empty.
// Reset (rst, synchronous, active high): menu idle, flags clear, hold 3000, cycle 1500 ms.
`timescale 1ns / 1ps
`include "single_switch_menu_selector_macros.svh"

module single_switch_menu_selector #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_ms,
  input  logic        switch_on,
  input  logic [5:0]  available_mask,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  selection,
  output logic [2:0]  fired_function,
  output logic        safehome_suspended,
  output logic        trackback_suspended,
  output logic        turtle_on,
  output logic        none_available,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ssms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  import ssms_pkg::*;

  // Input stage: hold one accepted item until the tick logic consumes it.
  logic                  stg_valid;
  logic [TIME_WIDTH-1:0] stg_now;
  logic                  stg_switch;
  logic [5:0]            stg_mask;

  // Menu state and configuration.
  logic [TIME_WIDTH-1:0] phase_time;
  logic [TIME_WIDTH-1:0] phase_time_next;
  menu_state_t           state;
  menu_state_t           state_next;
  result_t               step_result;
  logic [15:0]           hold_ms;
  logic [15:0]           cycle_ms;

  logic out_adv;
  logic step_go;

  // The result register may load when empty or when its item is being taken.
  assign out_adv   = !out_valid || out_ready;
  assign step_go   = stg_valid && out_adv;
  assign in_ready  = !stg_valid || out_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid <= 1'b1;
    end else if (step_go) begin
      stg_valid <= 1'b0;
    end
  end

  // Capture only the time bits the timer uses.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_now    <= now_ms[TIME_WIDTH-1:0];
      stg_switch <= switch_on;
      stg_mask   <= available_mask;
    end
  end

  ssms_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .now             (stg_now),
    .switch_on       (stg_switch),
    .available_mask  (stg_mask),
    .hold_ms         (hold_ms),
    .cycle_ms        (cycle_ms),
    .phase_time      (phase_time),
    .state           (state),
    .phase_time_next (phase_time_next),
    .state_next      (state_next),
    .result          (step_result)
  );

  // Advance the menu state once per consumed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_time <= '0;
      state      <= '{press_phase: PHASE_FIRST, current_item: ITEM_NONE, toggle_flags: 3'b000};
    end else if (step_go) begin
      phase_time <= phase_time_next;
      state      <= state_next;
    end
  end

  // Configuration: drop writes to indexes beyond the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms  <= HOLD_MS_RESET;
      cycle_ms <= CYCLE_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_MS:  hold_ms  <= cfg_data;
        REG_CYCLE_MS: cycle_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      selection           <= step_result.selection;
      fired_function      <= step_result.fired_function;
      safehome_suspended  <= step_result.safehome_suspended;
      trackback_suspended <= step_result.trackback_suspended;
      turtle_on           <= step_result.turtle_on;
      none_available      <= step_result.none_available;
    end
  end

  // A fired function always shows END.
  `SSMS_ASSERT_NOW(a_fire_shows_end, clk, rst, out_valid && fired_function != ITEM_NONE, selection == ITEM_END)
  // An empty scan leaves nothing selected.
  `SSMS_ASSERT_NOW(a_none_clears_sel, clk, rst, out_valid && none_available, selection == ITEM_NONE)
  // A consumed item always produces a result.
  `SSMS_ASSERT_NEXT(a_step_loads_out, clk, rst, step_go, out_valid)
  // Flags move only when an item is consumed.
  `SSMS_ASSERT_NEXT(a_flags_hold, clk, rst, !step_go, $stable(state.toggle_flags))

endmodule

[test/menu_checker.sv]
// Checker for the single switch menu selector: predicts each tick's result and compares it.
`timescale 1ns / 1ps

module menu_checker
  import ssms_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [31:0]                now_ms,
  input  logic                       switch_on,
  input  logic [5:0]                 available_mask,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [2:0]                 selection,
  input  logic [2:0]                 fired_function,
  input  logic                       safehome_suspended,
  input  logic                       trackback_suspended,
  input  logic                       turtle_on,
  input  logic                       none_available,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                cfg_data,
  output int                         pending_count,
  output int                         fail_count
);

  localparam logic [31:0] TIME_MASK =
    (TIME_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIME_WIDTH) - 32'd1);

  logic [15:0] hold_limit;
  logic [15:0] step_interval;
  logic [31:0] phase_stamp;
  phase_t      press_state;
  logic [2:0]  menu_item;
  logic [2:0]  toggles;

  result_t menu_results_q[$];
  int      mismatches;

  // Work out one tick of the menu and update the predicted state.
  function automatic result_t menu_tick(input logic [31:0] now_raw, input logic sw,
                                        input logic [5:0] avail);
    logic [31:0] now_t;
    logic [2:0]  fired;
    logic [2:0]  found;
    logic        none;
    logic        cancelled;
    result_t     res;
    now_t     = now_raw & TIME_MASK;
    fired     = ITEM_NONE;
    none      = 1'b0;
    cancelled = 1'b0;

    if (sw) begin
      if (phase_stamp == 32'd0) begin
        phase_stamp = now_t;
        menu_item   = ITEM_FIRST;
      end else if (press_state != PHASE_FIRST && menu_item != ITEM_END) begin
        press_state = PHASE_PRESSED;
        if (((now_t - phase_stamp) & TIME_MASK) > {16'd0, hold_limit}) begin
          if (menu_item >= ITEM_SAFEHOME && menu_item <= ITEM_TURTLE)
            toggles = toggles ^ (3'b001 << (menu_item - ITEM_SAFEHOME));
          if (menu_item >= ITEM_FIRST && menu_item <= ITEM_LAST)
            fired = menu_item;
          menu_item = ITEM_END;
        end
      end
    end else if (phase_stamp != 32'd0) begin
      if (press_state == PHASE_FIRST) begin
        phase_stamp = now_t;
      end else if (press_state == PHASE_PRESSED || menu_item == ITEM_NONE) begin
        phase_stamp = 32'd0;
        press_state = PHASE_FIRST;
        menu_item   = ITEM_NONE;
        cancelled   = 1'b1;
      end
      if (!cancelled) begin
        if (((now_t - phase_stamp) & TIME_MASK) > {16'd0, step_interval}) begin
          menu_item   = (menu_item >= ITEM_LAST) ? ITEM_FIRST : menu_item + 3'd1;
          phase_stamp = now_t;
        end
        press_state = PHASE_RELEASED;
      end
    end

    // Skip functions that are not available right now.
    if (!cancelled && menu_item >= ITEM_FIRST && menu_item <= ITEM_LAST) begin
      found = ITEM_NONE;
      for (int k = int'(menu_item); k <= int'(ITEM_LAST); k++) begin
        if (found == ITEM_NONE && avail[k-1])
          found = 3'(k);
      end
      if (found != ITEM_NONE) begin
        menu_item = found;
      end else if (menu_item == ITEM_FIRST) begin
        none      = 1'b1;
        menu_item = ITEM_NONE;
      end else begin
        menu_item = ITEM_FIRST;
      end
    end

    res.selection           = menu_item;
    res.fired_function      = fired;
    res.safehome_suspended  = toggles[0];
    res.trackback_suspended = toggles[1];
    res.turtle_on           = toggles[2];
    res.none_available      = none;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      hold_limit    = HOLD_MS_RESET;
      step_interval = CYCLE_MS_RESET;
      phase_stamp   = 32'd0;
      press_state   = PHASE_FIRST;
      menu_item     = ITEM_NONE;
      toggles       = 3'b000;
      menu_results_q.delete();
      mismatches    = 0;
      pending_count <= 0;
      fail_count    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOLD_MS:  hold_limit    = cfg_data;
          REG_CYCLE_MS: step_interval = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        menu_results_q.push_back(menu_tick(now_ms, switch_on, available_mask));
      if (out_valid && out_ready) begin
        got.selection           = selection;
        got.fired_function      = fired_function;
        got.safehome_suspended  = safehome_suspended;
        got.trackback_suspended = trackback_suspended;
        got.turtle_on           = turtle_on;
        got.none_available      = none_available;
        if (menu_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with nothing expected: sel %0d fired %0d", $realtime,
                     got.selection, got.fired_function);
        end else begin
          want = menu_results_q.pop_front();
          if (got.selection !== want.selection ||
              got.fired_function !== want.fired_function ||
              got.safehome_suspended !== want.safehome_suspended ||
              got.trackback_suspended !== want.trackback_suspended ||
              got.turtle_on !== want.turtle_on ||
              got.none_available !== want.none_available) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0t] mismatch (exp/act): sel %0d/%0d fired %0d/%0d ",
                        "flags %b%b%b/%b%b%b none %b/%b"}, $realtime,
                       want.selection, got.selection,
                       want.fired_function, got.fired_function,
                       want.turtle_on, want.trackback_suspended, want.safehome_suspended,
                       got.turtle_on, got.trackback_suspended, got.safehome_suspended,
                       want.none_available, got.none_available);
          end
        end
      end
      pending_count <= menu_results_q.size();
      fail_count    <= mismatches;
    end
  end

endmodule

[test/single_switch_menu_selector_tb.sv]
// Testbench top for the single switch menu selector: stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module single_switch_menu_selector_tb;
  import ssms_pkg::*;

  localparam int TIME_W       = 32;
  localparam int ITEM_TARGET  = 1900;  // rough size of the run, directed ticks included
  localparam int PHASE_ITEMS  = 140;   // divided by 12, gives the sessions between two configuration changes
  localparam int QUIET_LIMIT  = 4000;  // cycles without any handshake before giving up
  localparam int DRAIN_SETTLE = 4;     // margin after the last result is taken
  localparam int TAIL_CYCLES  = 10;

  // Register indexes the block does not implement; writes to them must be dropped.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] now_ms = 32'd0;
  logic        switch_on = 1'b0;
  logic [5:0]  available_mask = 6'd0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  selection;
  logic [2:0]  fired_function;
  logic        safehome_suspended;
  logic        trackback_suspended;
  logic        turtle_on;
  logic        none_available;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_HOLD_MS;
  logic [15:0]                cfg_data = 16'd0;

  int pending_count;
  int fail_count;

  // Stimulus bookkeeping.
  logic [31:0] menu_time = 32'd0;   // last time stamp sent
  logic [15:0] hold_setting  = HOLD_MS_RESET;
  logic [15:0] cycle_setting = CYCLE_MS_RESET;
  int          items_sent = 0;
  bit          in_calm  = 1'b0;     // no gaps on the item side
  bit          out_calm = 1'b0;     // no stalls on the result side
  int          ready_span = 0;
  int          quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  single_switch_menu_selector #(
    .TIME_WIDTH(TIME_W)
  ) u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .now_ms             (now_ms),
    .switch_on          (switch_on),
    .available_mask     (available_mask),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .selection          (selection),
    .fired_function     (fired_function),
    .safehome_suspended (safehome_suspended),
    .trackback_suspended(trackback_suspended),
    .turtle_on          (turtle_on),
    .none_available     (none_available),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  menu_checker #(
    .TIME_WIDTH(TIME_W)
  ) u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .now_ms             (now_ms),
    .switch_on          (switch_on),
    .available_mask     (available_mask),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .selection          (selection),
    .fired_function     (fired_function),
    .safehome_suspended (safehome_suspended),
    .trackback_suspended(trackback_suspended),
    .turtle_on          (turtle_on),
    .none_available     (none_available),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .pending_count      (pending_count),
    .fail_count         (fail_count)
  );

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Availability masks: favor all, none and single functions next to plain random ones.
  function automatic logic [5:0] pick_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 6'($urandom);
    if (r < 70) return 6'h3F;
    if (r < 85) return 6'h00;
    return 6'b000001 << $urandom_range(0, 5);
  endfunction

  // Advance the clock in steps scaled to the current hold and cycle settings,
  // so that sessions cross both thresholds; jump far once in a while.
  function automatic logic [31:0] next_time();
    int unsigned span;
    span = (hold_setting > cycle_setting) ? hold_setting : cycle_setting;
    if ($urandom_range(0, 99) < 2) return menu_time + $urandom;
    return menu_time + $urandom_range(0, span / 4 + 3);
  endfunction

  // Result side: hold ready high for short runs, drop it for random stalls.
  always @(posedge clk) begin : ready_gen
    int stall;
    if (ready_span != 0) begin
      ready_span <= ready_span - 1;
    end else if (out_ready) begin
      stall = pick_gap(out_calm);
      if (stall != 0) begin
        out_ready  <= 1'b0;
        ready_span <= stall - 1;
      end
    end else begin
      out_ready  <= 1'b1;
      ready_span <= $urandom_range(0, 8);
    end
  end

  // Watchdog: count cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one tick; keep valid high after acceptance so back-to-back ticks
  // do not need in_valid to fall and rise between them.
  task automatic tick_at(input logic [31:0] t, input logic sw, input logic [5:0] m);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    now_ms         <= t;
    switch_on      <= sw;
    available_mask <= m;
    menu_time = t;
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic tick(input logic sw);
    tick_at(next_time(), sw, pick_mask());
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pick the settings for one phase: zero, maximum, reset values, then small random ones.
  task automatic configure(input int phase);
    logic [15:0] h;
    logic [15:0] c;
    case (phase % 6)
      0: begin
        h = 16'd0;
        c = 16'd0;
      end
      1: begin
        h = 16'hFFFF;
        c = 16'hFFFF;
      end
      2: begin
        h = HOLD_MS_RESET;
        c = CYCLE_MS_RESET;
      end
      3: begin
        h = 16'd0;
        c = 16'($urandom_range(1, 150));
      end
      4: begin
        h = 16'($urandom_range(1, 300));
        c = 16'd0;
      end
      default: begin
        h = 16'($urandom_range(1, 300));
        c = 16'($urandom_range(1, 150));
      end
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(REG_HOLD_MS, h);
      write_reg(REG_CYCLE_MS, c);
    end else begin
      write_reg(REG_CYCLE_MS, c);
      write_reg(REG_HOLD_MS, h);
    end
    // Unimplemented indexes must leave both settings alone.
    if (phase % 3 == 1)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    hold_setting  = h;
    cycle_setting = c;
    // Start some phases just below the wrap of the time stamp.
    if ($urandom_range(0, 3) == 0)
      menu_time = 32'hFFFF_FFFF - $urandom_range(0, 3 * (int'(h) + int'(c)) + 10);
  endtask

  // One menu session: open, release to step, press to apply, release to close.
  // One session in five, at random, is noise: random levels, some zero or random stamps.
  task automatic run_session();
    int n;
    if ($urandom_range(0, 99) < 80) begin
      n = $urandom_range(1, 3);
      repeat (n) tick(1'b1);
      n = $urandom_range(1, 12);
      repeat (n) tick(1'b0);
      n = $urandom_range(1, 8);
      repeat (n) tick(1'b1);
      n = $urandom_range(1, 2);
      repeat (n) tick(1'b0);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0:       tick_at(32'd0, 1'($urandom), pick_mask());
          1:       tick_at($urandom, 1'($urandom), pick_mask());
          default: tick(1'($urandom));
        endcase
      end
    end
  endtask

  // Directed ticks with the reset settings (hold 3000, cycle 1500).
  task automatic run_directed();
    // Press at time zero: the stamp reads as idle.
    tick_at(32'd0,     1'b1, 6'h3F);
    tick_at(32'd100,   1'b0, 6'h3F);
    // Open, step to function 3, hold past the limit to toggle trackback, release.
    tick_at(32'd1000,  1'b1, 6'h3F);
    tick_at(32'd1100,  1'b1, 6'h3F);
    tick_at(32'd1200,  1'b0, 6'h3F);
    tick_at(32'd2701,  1'b0, 6'h3F);
    tick_at(32'd4202,  1'b0, 6'h3F);
    tick_at(32'd4400,  1'b1, 6'h3F);
    tick_at(32'd7401,  1'b1, 6'h3F);
    tick_at(32'd7600,  1'b0, 6'h3F);
    // Nothing available from function 1: menu ends, then release cancels.
    tick_at(32'd8000,  1'b1, 6'h00);
    tick_at(32'd8100,  1'b0, 6'h00);
    tick_at(32'd8200,  1'b0, 6'h00);
    // Apply while nothing is selected: no function fires, END still shows.
    tick_at(32'd9000,  1'b1, 6'h00);
    tick_at(32'd9100,  1'b0, 6'h00);
    tick_at(32'd9200,  1'b1, 6'h00);
    tick_at(32'd12300, 1'b1, 6'h00);
    tick_at(32'd12400, 1'b0, 6'h00);
    // Skip to function 6, wrap back to 1, skip to 5, run out above 5, apply.
    tick_at(32'd13000, 1'b1, 6'h20);
    tick_at(32'd13100, 1'b0, 6'h20);
    tick_at(32'd14700, 1'b0, 6'h01);
    tick_at(32'd14800, 1'b0, 6'h10);
    tick_at(32'd14850, 1'b0, 6'h01);
    tick_at(32'd14900, 1'b1, 6'h3F);
    tick_at(32'd18000, 1'b1, 6'h3F);
  endtask

  initial begin : stimulus
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      // Pause the sender until every result is back before touching registers.
      drain_results();
      configure(phase);
      in_calm  = (phase % 5 == 2) || (phase % 7 == 4);
      out_calm = (phase % 5 == 2);
      repeat (PHASE_ITEMS / 12) begin
        if (items_sent < ITEM_TARGET)
          run_session();
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
